>>> src/nvtn_pkg.sv
`timescale 1ns / 1ps

package nvtn_pkg;

    // Vector component width; 1.0 reads as 1 << (VEC_W - 2).
    localparam int VEC_W = 16;
    localparam logic signed [VEC_W-1:0] UNIT_ONE = VEC_W'(1) << (VEC_W - 2);

    // Matrix rows and cofactors.
    localparam int ROW_W   = 48;
    localparam int SLOT_W  = 16;
    localparam int COF_W   = 2 * SLOT_W + 1;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

    // Input beat.
    typedef struct packed {
        logic signed [VEC_W-1:0] normal_x;
        logic signed [VEC_W-1:0] normal_y;
        logic signed [VEC_W-1:0] normal_z;
    } nvtn_in_t;

    // Result beat.
    typedef struct packed {
        logic signed [VEC_W-1:0] unit_x;
        logic signed [VEC_W-1:0] unit_y;
        logic signed [VEC_W-1:0] unit_z;
        logic                    zero_length;
        logic                    singular_matrix;
    } nvtn_out_t;

    // Matrix state handed from the cofactor unit to the datapath.
    typedef struct packed {
        logic [8:0][COF_W-1:0] cof;
        logic                  det_neg;
        logic                  det_zero;
        logic                  busy;
    } nvtn_coef_t;

endpackage

>>> src/nvtn_cofactor.sv
`timescale 1ns / 1ps

module nvtn_cofactor
    import nvtn_pkg::*;
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data,
    output nvtn_coef_t           coef
);

    localparam int CB    = (COEF_WIDTH < SLOT_W) ? COEF_WIDTH : SLOT_W;
    localparam int DETPW = SLOT_W + COF_W;
    localparam int DETW  = DETPW + 2;

    logic [ROW_W-1:0]         row_reg [3];
    logic signed [SLOT_W-1:0] t [3][3];
    logic signed [COF_W-1:0]  cof_reg [9];
    logic signed [COF_W-1:0]  cof_next [9];
    logic signed [DETPW-1:0]  detp_reg [3];
    logic signed [DETW-1:0]   det_sum;
    logic                     det_neg_reg;
    logic                     det_zero_reg;
    logic [1:0]               busy_reg;
    logic [1:0]               busy_next;

    // Matrix registers, identity after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_W'(48'd4096);
            row_reg[1] <= ROW_W'(48'd4096) << SLOT_W;
            row_reg[2] <= ROW_W'(48'd4096) << (2 * SLOT_W);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0: row_reg[0] <= cfg_data;
                REG_ROW1: row_reg[1] <= cfg_data;
                REG_ROW2: row_reg[2] <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Entries are the low CB bits of each slot, sign extended.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t[r][c] = SLOT_W'($signed(row_reg[r][SLOT_W*c +: CB]));
            end
        end
    end

    // Cofactors: each is one pair of products and a difference.
    always_comb
    begin
        int r1, r2, c1, c2;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                r1 = (i == 2) ? 0 : i + 1;
                r2 = (i == 0) ? 2 : i - 1;
                c1 = (j == 2) ? 0 : j + 1;
                c2 = (j == 0) ? 2 : j - 1;
                cof_next[3*i+j] = COF_W'(t[r1][c1] * t[r2][c2])
                                - COF_W'(t[r1][c2] * t[r2][c1]);
            end
        end
    end

    // Determinant terms are registered, then summed for the sign.
    assign det_sum = DETW'(detp_reg[0]) + DETW'(detp_reg[1]) + DETW'(detp_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            cof_reg[k] <= cof_next[k];
        end
        for (int j = 0; j < 3; j++)
        begin
            detp_reg[j] <= DETPW'(t[0][j] * cof_reg[j]);
        end
        det_neg_reg  <= det_sum < 0;
        det_zero_reg <= det_sum == 0;
    end

    // Busy stays set after a write or reset until the cofactor, determinant-term and sign registers have settled.
    always_comb
    begin
        if (cfg_we)
        begin
            busy_next = 2'd3;
        end
        else if (busy_reg != 2'd0)
        begin
            busy_next = busy_reg - 2'd1;
        end
        else
        begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 2'd3;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            coef.cof[k] = cof_reg[k];
        end
        coef.det_neg  = det_neg_reg;
        coef.det_zero = det_zero_reg;
        coef.busy     = busy_reg != 2'd0;
    end

endmodule

>>> src/nvtn_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage.
module nvtn_sqrt
    import nvtn_pkg::*;
#(
    parameter int IN_W   = 62,
    parameter int SIDE_W = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                src_valid,
    input  logic [IN_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]   src_side,
    output logic                res_valid,
    output logic [IN_W/2-1:0]   root,
    output logic [SIDE_W-1:0]   res_side
);

    localparam int ST   = IN_W / 2;
    localparam int REMW = ST + 2;
    localparam int RNW  = REMW + 2;

    logic [IN_W-1:0]   x_src [ST], x_nxt [ST], x_reg [ST];
    logic [REMW-1:0]   rem_src [ST], rem_nxt [ST], rem_reg [ST];
    logic [ST-1:0]     rt_src [ST], rt_nxt [ST], rt_reg [ST];
    logic [SIDE_W-1:0] side_src [ST], side_reg [ST];
    logic              vld_src [ST], vld_reg [ST];
    logic [RNW-1:0]    rn [ST];
    logic [RNW-1:0]    trial [ST];

    // Stage inputs: the first takes the port, the rest the previous stage.
    always_comb
    begin
        x_src[0]    = radicand;
        rem_src[0]  = '0;
        rt_src[0]   = '0;
        side_src[0] = src_side;
        vld_src[0]  = src_valid;
        for (int g = 1; g < ST; g++)
        begin
            x_src[g]    = x_reg[g-1];
            rem_src[g]  = rem_reg[g-1];
            rt_src[g]   = rt_reg[g-1];
            side_src[g] = side_reg[g-1];
            vld_src[g]  = vld_reg[g-1];
        end
    end

    // One restoring step per stage: bring down two bits, try a root bit.
    always_comb
    begin
        for (int g = 0; g < ST; g++)
        begin
            rn[g]    = {rem_src[g], x_src[g][IN_W-1 -: 2]};
            trial[g] = RNW'({rt_src[g], 2'b01});
            x_nxt[g] = x_src[g] << 2;
            if (rn[g] >= trial[g])
            begin
                rem_nxt[g] = REMW'(rn[g] - trial[g]);
                rt_nxt[g]  = {rt_src[g][ST-2:0], 1'b1};
            end
            else
            begin
                rem_nxt[g] = REMW'(rn[g]);
                rt_nxt[g]  = {rt_src[g][ST-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < ST; g++)
            begin
                x_reg[g]    <= x_nxt[g];
                rem_reg[g]  <= rem_nxt[g];
                rt_reg[g]   <= rt_nxt[g];
                side_reg[g] <= side_src[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < ST; g++)
            begin
                vld_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int g = 0; g < ST; g++)
            begin
                vld_reg[g] <= vld_src[g];
            end
        end
    end

    assign res_valid = vld_reg[ST-1];
    assign root      = rt_reg[ST-1];
    assign res_side  = side_reg[ST-1];

endmodule

>>> src/nvtn_div.sv
`timescale 1ns / 1ps

// Three-lane pipelined restoring divider sharing one divisor,
// one quotient bit per stage.
module nvtn_div
    import nvtn_pkg::*;
#(
    parameter int NUM_W  = 46,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 15,
    parameter int SIDE_W = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                src_valid,
    input  logic [NUM_W-1:0]    num [3],
    input  logic [DEN_W-1:0]    den,
    input  logic [SIDE_W-1:0]   src_side,
    output logic                res_valid,
    output logic [Q_W-1:0]      quot [3],
    output logic [SIDE_W-1:0]   res_side
);

    localparam int ST = Q_W;

    logic [DEN_W-1:0]  r_src [ST][3], r_nxt [ST][3], r_reg [ST][3];
    logic [Q_W-1:0]    lo_src [ST][3], lo_reg [ST][3];
    logic [Q_W-1:0]    q_src [ST][3], q_nxt [ST][3], q_reg [ST][3];
    logic [DEN_W-1:0]  d_src [ST], d_reg [ST];
    logic [SIDE_W-1:0] side_src [ST], side_reg [ST];
    logic              vld_src [ST], vld_reg [ST];
    logic [DEN_W:0]    rn [ST][3];

    // Stage inputs. The numerator's high part starts as the remainder.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            r_src[0][l]  = DEN_W'(num[l] >> Q_W);
            lo_src[0][l] = num[l][Q_W-1:0];
            q_src[0][l]  = '0;
        end
        d_src[0]    = den;
        side_src[0] = src_side;
        vld_src[0]  = src_valid;
        for (int g = 1; g < ST; g++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                r_src[g][l]  = r_reg[g-1][l];
                lo_src[g][l] = lo_reg[g-1][l];
                q_src[g][l]  = q_reg[g-1][l];
            end
            d_src[g]    = d_reg[g-1];
            side_src[g] = side_reg[g-1];
            vld_src[g]  = vld_reg[g-1];
        end
    end

    // Shift in the next numerator bit, subtract if it fits.
    always_comb
    begin
        for (int g = 0; g < ST; g++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rn[g][l] = {r_src[g][l], lo_src[g][l][Q_W-1]};
                if (rn[g][l] >= {1'b0, d_src[g]})
                begin
                    r_nxt[g][l] = DEN_W'(rn[g][l] - {1'b0, d_src[g]});
                    q_nxt[g][l] = {q_src[g][l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    r_nxt[g][l] = DEN_W'(rn[g][l]);
                    q_nxt[g][l] = {q_src[g][l][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < ST; g++)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    r_reg[g][l]  <= r_nxt[g][l];
                    lo_reg[g][l] <= lo_src[g][l] << 1;
                    q_reg[g][l]  <= q_nxt[g][l];
                end
                d_reg[g]    <= d_src[g];
                side_reg[g] <= side_src[g];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < ST; g++)
            begin
                vld_reg[g] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int g = 0; g < ST; g++)
            begin
                vld_reg[g] <= vld_src[g];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            quot[l] = q_reg[ST-1][l];
        end
    end

    assign res_valid = vld_reg[ST-1];
    assign res_side  = side_reg[ST-1];

endmodule

>>> src/normal_vector_transform_normalize.sv
`timescale 1ns / 1ps

// Transforms each normal by the inverse-transpose of the loaded 3x3 matrix
// and scales it to unit length (Q1.14). One beat is accepted per cycle
// while normal_stall is low; a result passes through the front stages,
// the pipelined square root (one bit per stage), the pipelined divider
// (one quotient bit per stage) and the output register. After reset and
// after every register write the input stalls while the cofactors and
// the determinant sign are recomputed. A singular matrix gives a zero
// vector with singular_matrix set; a vector that transforms to zero
// gives zero with zero_length set.
module normal_vector_transform_normalize
    import nvtn_pkg::*;
#(
    parameter int COEF_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ROW_W-1:0]     cfg_data,
    input  logic                 normal_valid,
    output logic                 normal_stall,
    input  nvtn_in_t             normal,
    output logic                 unit_valid,
    input  logic                 unit_stall,
    output nvtn_out_t            unit
);

    localparam int VW   = VEC_W;
    localparam int PW   = COF_W + VW + 1;
    localparam int VSW  = PW + 2;
    localparam int WW   = 30;
    localparam int SHW  = $clog2(VSW - WW + 1);
    localparam int POSW = $clog2(VSW);
    localparam int SQW  = 2 * WW;
    localparam int L2W  = SQW + 2;
    localparam int LENW = L2W / 2;
    localparam int QW   = VW - 1;
    localparam int NW   = WW + QW + 1;
    localparam int DW   = LENW + 1;
    localparam int SSW  = 3 * WW + 5;
    localparam int DSW  = 5;

    nvtn_coef_t coef;
    logic       adv;
    logic       accept;

    logic signed [VW:0]    nsg [3];
    logic signed [PW-1:0]  s1_prod_reg [3][3];
    logic                  s1_sing_reg;
    logic signed [VSW-1:0] s2_v_reg [3];
    logic                  s2_sing_reg;
    logic [VSW-1:0]        s3_mag_reg [3];
    logic [2:0]            s3_neg_reg;
    logic                  s3_sing_reg;
    logic [VSW-1:0]        s4_mag_reg [3];
    logic [VSW-1:0]        s4_m_reg;
    logic [2:0]            s4_neg_reg;
    logic                  s4_sing_reg;
    logic                  s4_zero_reg;
    logic [VSW-1:0]        m01;
    logic [POSW-1:0]       msb_pos;
    logic [SHW-1:0]        sh_next;
    logic [VSW-1:0]        s5_mag_reg [3];
    logic [SHW-1:0]        s5_sh_reg;
    logic [2:0]            s5_neg_reg;
    logic                  s5_sing_reg;
    logic                  s5_zero_reg;
    logic [WW-1:0]         s6_w_reg [3];
    logic [2:0]            s6_neg_reg;
    logic                  s6_sing_reg;
    logic                  s6_zero_reg;
    logic [SQW-1:0]        s7_sq_reg [3];
    logic [WW-1:0]         s7_w_reg [3];
    logic [2:0]            s7_neg_reg;
    logic                  s7_sing_reg;
    logic                  s7_zero_reg;
    logic [L2W-1:0]        s8_l2_reg;
    logic [WW-1:0]         s8_w_reg [3];
    logic [2:0]            s8_neg_reg;
    logic                  s8_sing_reg;
    logic                  s8_zero_reg;
    logic [7:0]            vld_reg;

    logic                  sq_valid;
    logic [LENW-1:0]       sq_root;
    logic [SSW-1:0]        sq_side;
    logic [LENW-1:0]       len1;
    logic [NW-1:0]         div_num [3];
    logic [DW-1:0]         div_den;
    logic                  dv_valid;
    logic [QW-1:0]         dv_quot [3];
    logic [DSW-1:0]        dv_side;
    logic [QW-1:0]         qc [3];
    logic signed [VW-1:0]  uval [3];
    nvtn_out_t             unit_next;
    logic                  unit_valid_reg;
    nvtn_out_t             unit_reg;

    nvtn_cofactor #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // The whole pipeline moves unless a finished result is held.
    assign adv          = !unit_valid_reg || !unit_stall;
    assign normal_stall = !adv || coef.busy;
    assign accept       = normal_valid && !normal_stall;

    // Apply the determinant sign to the input before the multipliers.
    always_comb
    begin
        nsg[0] = (VW+1)'(normal.normal_x);
        nsg[1] = (VW+1)'(normal.normal_y);
        nsg[2] = (VW+1)'(normal.normal_z);
        for (int j = 0; j < 3; j++)
        begin
            if (coef.det_neg)
            begin
                nsg[j] = -nsg[j];
            end
        end
    end

    // Largest magnitude and its leading one.
    assign m01 = (s3_mag_reg[0] > s3_mag_reg[1]) ? s3_mag_reg[0] : s3_mag_reg[1];

    always_comb
    begin
        msb_pos = '0;
        for (int b = 0; b < VSW; b++)
        begin
            if (s4_m_reg[b])
            begin
                msb_pos = POSW'(b);
            end
        end
        if (msb_pos >= POSW'(WW))
        begin
            sh_next = SHW'(msb_pos - POSW'(WW - 1));
        end
        else
        begin
            sh_next = '0;
        end
    end

    // Front stages: products, sums, magnitudes, maximum, shift, squares and their sum.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s1_prod_reg[i][j] <= PW'($signed(coef.cof[3*i+j]) * nsg[j]);
                end
            end
            s1_sing_reg <= coef.det_zero;

            for (int i = 0; i < 3; i++)
            begin
                s2_v_reg[i] <= VSW'(s1_prod_reg[i][0]) + VSW'(s1_prod_reg[i][1])
                             + VSW'(s1_prod_reg[i][2]);
            end
            s2_sing_reg <= s1_sing_reg;

            for (int i = 0; i < 3; i++)
            begin
                s3_neg_reg[i] <= s2_v_reg[i][VSW-1];
                s3_mag_reg[i] <= s2_v_reg[i][VSW-1] ? VSW'(-s2_v_reg[i])
                                                    : VSW'(s2_v_reg[i]);
            end
            s3_sing_reg <= s2_sing_reg;

            s4_mag_reg  <= s3_mag_reg;
            s4_m_reg    <= (m01 > s3_mag_reg[2]) ? m01 : s3_mag_reg[2];
            s4_zero_reg <= (m01 == '0) && (s3_mag_reg[2] == '0);
            s4_neg_reg  <= s3_neg_reg;
            s4_sing_reg <= s3_sing_reg;

            s5_mag_reg  <= s4_mag_reg;
            s5_sh_reg   <= sh_next;
            s5_neg_reg  <= s4_neg_reg;
            s5_sing_reg <= s4_sing_reg;
            s5_zero_reg <= s4_zero_reg;

            for (int i = 0; i < 3; i++)
            begin
                s6_w_reg[i] <= WW'(s5_mag_reg[i] >> s5_sh_reg);
            end
            s6_neg_reg  <= s5_neg_reg;
            s6_sing_reg <= s5_sing_reg;
            s6_zero_reg <= s5_zero_reg;

            for (int i = 0; i < 3; i++)
            begin
                s7_sq_reg[i] <= SQW'(s6_w_reg[i] * s6_w_reg[i]);
            end
            s7_w_reg    <= s6_w_reg;
            s7_neg_reg  <= s6_neg_reg;
            s7_sing_reg <= s6_sing_reg;
            s7_zero_reg <= s6_zero_reg;

            s8_l2_reg   <= L2W'(s7_sq_reg[0]) + L2W'(s7_sq_reg[1]) + L2W'(s7_sq_reg[2]);
            s8_w_reg    <= s7_w_reg;
            s8_neg_reg  <= s7_neg_reg;
            s8_sing_reg <= s7_sing_reg;
            s8_zero_reg <= s7_zero_reg;
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[6:0], accept};
        end
    end

    nvtn_sqrt #(
        .IN_W   (L2W),
        .SIDE_W (SSW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .src_valid (vld_reg[7]),
        .radicand  (s8_l2_reg),
        .src_side  ({s8_w_reg[0], s8_w_reg[1], s8_w_reg[2], s8_neg_reg,
                     s8_zero_reg, s8_sing_reg}),
        .res_valid (sq_valid),
        .root      (sq_root),
        .res_side  (sq_side)
    );

    // Rounded quotient: (2 w ONE + len) / (2 len).
    assign len1    = (sq_root == '0) ? LENW'(1) : sq_root;
    assign div_den = {len1, 1'b0};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            div_num[i] = NW'({sq_side[SSW-1-WW*i -: WW], {QW{1'b0}}}) + NW'(len1);
        end
    end

    nvtn_div #(
        .NUM_W  (NW),
        .DEN_W  (DW),
        .Q_W    (QW),
        .SIDE_W (DSW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .src_valid (sq_valid),
        .num       (div_num),
        .den       (div_den),
        .src_side  (sq_side[DSW-1:0]),
        .res_valid (dv_valid),
        .quot      (dv_quot),
        .res_side  (dv_side)
    );

    // Clamp, restore signs and apply the special cases.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qc[i] = (dv_quot[i] > QW'(UNIT_ONE)) ? QW'(UNIT_ONE) : dv_quot[i];
            uval[i] = dv_side[2+i] ? -VW'(qc[i]) : VW'(qc[i]);
        end
        unit_next.unit_x          = uval[0];
        unit_next.unit_y          = uval[1];
        unit_next.unit_z          = uval[2];
        unit_next.zero_length     = 1'b0;
        unit_next.singular_matrix = 1'b0;
        if (dv_side[0])
        begin
            unit_next.unit_x          = '0;
            unit_next.unit_y          = '0;
            unit_next.unit_z          = '0;
            unit_next.singular_matrix = 1'b1;
        end
        else if (dv_side[1])
        begin
            unit_next.unit_x      = '0;
            unit_next.unit_y      = '0;
            unit_next.unit_z      = '0;
            unit_next.zero_length = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            unit_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unit_reg <= unit_next;
        end
    end

    assign unit_valid = unit_valid_reg;
    assign unit       = unit_reg;

`ifndef SYNTHESIS
    // A write holds off new beats until the derived state has settled.
    assert_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> normal_stall)
        else $error("beat accepted right after a register write");

    // The two special cases never occur together.
    assert_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid |-> !(unit.zero_length && unit.singular_matrix))
        else $error("zero_length and singular_matrix both set");

    // A flagged result carries a zero vector.
    assert_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && (unit.zero_length || unit.singular_matrix)
        |-> unit.unit_x == '0 && unit.unit_y == '0 && unit.unit_z == '0)
        else $error("flagged result with nonzero vector");

    // Every component stays within one unit.
    assert_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid |-> unit.unit_x <= UNIT_ONE && unit.unit_x >= -UNIT_ONE
                    && unit.unit_y <= UNIT_ONE && unit.unit_y >= -UNIT_ONE
                    && unit.unit_z <= UNIT_ONE && unit.unit_z >= -UNIT_ONE)
        else $error("unit component out of range");
`endif

endmodule

>>> test/normal_vector_transform_normalize_tb.sv
`timescale 1ns / 1ps

module normal_vector_transform_normalize_tb;
    import nvtn_pkg::*;

    // An index past the last matrix row; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PIPE_DRAIN = 70;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1800;

    // A directed row: a normal and, where it is obvious, the result it must give.
    typedef struct {
        nvtn_in_t  vec;
        bit        typed;
        nvtn_out_t result;
    } normal_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;
    logic                 normal_valid;
    logic                 normal_stall;
    nvtn_in_t             normal;
    logic                 unit_valid;
    logic                 unit_stall;
    nvtn_out_t            unit;

    // Copy of the matrix state the block is expected to hold.
    logic [ROW_W-1:0] model_rows [3];
    longint           model_cof [9];
    int               model_det_sign;

    nvtn_out_t pending_units [$];
    int        mismatch_count;
    int        cycle_count;
    bit        hold_request;

    normal_vector_transform_normalize u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .normal_valid (normal_valid),
        .normal_stall (normal_stall),
        .normal       (normal),
        .unit_valid   (unit_valid),
        .unit_stall   (unit_stall),
        .unit         (unit)
    );

    // Clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run-length guard.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic longint matrix_entry(int r, int c);
        logic signed [SLOT_W-1:0] slot;
        slot = model_rows[r][SLOT_W*c +: SLOT_W];
        return longint'(slot);
    endfunction

    // Cofactors and determinant sign of the current matrix.
    function automatic void update_cofactors();
        longint t [3][3];
        longint det;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t[r][c] = matrix_entry(r, c);
            end
        end
        model_cof[0] = t[1][1] * t[2][2] - t[1][2] * t[2][1];
        model_cof[1] = t[1][2] * t[2][0] - t[1][0] * t[2][2];
        model_cof[2] = t[1][0] * t[2][1] - t[1][1] * t[2][0];
        model_cof[3] = t[2][1] * t[0][2] - t[2][2] * t[0][1];
        model_cof[4] = t[2][2] * t[0][0] - t[2][0] * t[0][2];
        model_cof[5] = t[2][0] * t[0][1] - t[2][1] * t[0][0];
        model_cof[6] = t[0][1] * t[1][2] - t[0][2] * t[1][1];
        model_cof[7] = t[0][2] * t[1][0] - t[0][0] * t[1][2];
        model_cof[8] = t[0][0] * t[1][1] - t[0][1] * t[1][0];
        det = t[0][0] * model_cof[0] + t[0][1] * model_cof[1] + t[0][2] * model_cof[2];
        model_det_sign = (det > 0) ? 1 : ((det < 0) ? -1 : 0);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > x)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (x >= root + probe)
            begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Transformed, unit-length normal for one input beat.
    function automatic nvtn_out_t unit_normal(nvtn_in_t vec);
        nvtn_out_t       res;
        longint          comp [3];
        longint          prod;
        longint unsigned mag [3];
        bit              neg [3];
        longint unsigned peak;
        longint unsigned len_sq;
        longint unsigned len;
        longint unsigned q;
        longint unsigned one;
        int              shift;
        res  = '0;
        one  = 64'd1 << (VEC_W - 2);
        peak = 0;
        if (model_det_sign == 0)
        begin
            res.singular_matrix = 1'b1;
            return res;
        end
        comp[0] = longint'(vec.normal_x);
        comp[1] = longint'(vec.normal_y);
        comp[2] = longint'(vec.normal_z);
        for (int i = 0; i < 3; i++)
        begin
            prod = model_cof[3*i] * comp[0] + model_cof[3*i+1] * comp[1]
                 + model_cof[3*i+2] * comp[2];
            if (model_det_sign < 0)
            begin
                prod = -prod;
            end
            neg[i] = prod < 0;
            mag[i] = neg[i] ? longint'(-prod) : longint'(prod);
            if (mag[i] > peak)
            begin
                peak = mag[i];
            end
        end
        if (peak == 0)
        begin
            res.zero_length = 1'b1;
            return res;
        end
        shift = 0;
        while ((peak >> shift) >= (64'd1 << 30))
        begin
            shift++;
        end
        len_sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = mag[i] >> shift;
            len_sq = len_sq + mag[i] * mag[i];
        end
        len = int_sqrt(len_sq);
        if (len == 0)
        begin
            len = 1;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = (2 * mag[i] * one + len) / (2 * len);
            if (q > one)
            begin
                q = one;
            end
            comp[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        res.unit_x = comp[0][VEC_W-1:0];
        res.unit_y = comp[1][VEC_W-1:0];
        res.unit_z = comp[2][VEC_W-1:0];
        return res;
    endfunction

    // Receiver: the stall pattern is redrawn at random from four modes; a hold request
    // stalls the output for a long stretch so the pipeline backs up.
    int stall_mode;
    int hold_left;

    initial
    begin
        stall_mode = 0;
        hold_left  = 0;
    end

    always @(posedge clk)
    begin
        if (unit_valid && !unit_stall)
        begin
            check_unit(unit);
        end
        if (cycle_count % 200 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        if (hold_request && hold_left == 0)
        begin
            hold_request = 1'b0;
            hold_left    = 300;
        end
        if (hold_left > 0)
        begin
            hold_left  = hold_left - 1;
            unit_stall <= 1'b1;
        end
        else
        begin
            case (stall_mode)
                0: unit_stall <= 1'b0;
                1: unit_stall <= ($urandom_range(0, 9) < 3);
                2: unit_stall <= (cycle_count % 4 == 0);
                default: unit_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    task automatic check_unit(nvtn_out_t got);
        nvtn_out_t want;
        if (pending_units.size() == 0)
        begin
            $display("%0t: unexpected result beat %h", $time, got);
            mismatch_count++;
        end
        else
        begin
            want = pending_units.pop_front();
            if (got.unit_x !== want.unit_x || got.unit_y !== want.unit_y
                || got.unit_z !== want.unit_z || got.zero_length !== want.zero_length
                || got.singular_matrix !== want.singular_matrix)
            begin
                $display("%0t: mismatch expected x=%0d y=%0d z=%0d zl=%b sg=%b",
                         $time, want.unit_x, want.unit_y, want.unit_z,
                         want.zero_length, want.singular_matrix);
                $display("%0t:          actual   x=%0d y=%0d z=%0d zl=%b sg=%b",
                         $time, got.unit_x, got.unit_y, got.unit_z,
                         got.zero_length, got.singular_matrix);
                mismatch_count++;
            end
        end
    endtask

    // Offer one beat, wait for it to be taken, then leave an optional gap.
    task automatic send_normal(nvtn_in_t vec, bit typed, nvtn_out_t typed_result, int gap);
        normal_valid <= 1'b1;
        normal       <= vec;
        @(posedge clk);
        while (normal_stall)
        begin
            @(posedge clk);
        end
        pending_units.push_back(typed ? typed_result : unit_normal(vec));
        if (gap > 0)
        begin
            normal_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register write, only once the pipeline has drained.
    task automatic write_row(logic [CFG_IDX_W-1:0] index, logic [ROW_W-1:0] value);
        normal_valid <= 1'b0;
        while (pending_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index != REG_UNUSED)
        begin
            model_rows[index] = value;
            update_cofactors();
        end
    endtask

    task automatic load_matrix(logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                               logic [ROW_W-1:0] r2);
        write_row(REG_ROW0, r0);
        write_row(REG_ROW1, r1);
        write_row(REG_ROW2, r2);
    endtask

    function automatic nvtn_in_t vec3(int x, int y, int z);
        nvtn_in_t v;
        v.normal_x = x[VEC_W-1:0];
        v.normal_y = y[VEC_W-1:0];
        v.normal_z = z[VEC_W-1:0];
        return v;
    endfunction

    function automatic nvtn_out_t unit3(int x, int y, int z, bit zl, bit sg);
        nvtn_out_t r;
        r.unit_x          = x[VEC_W-1:0];
        r.unit_y          = y[VEC_W-1:0];
        r.unit_z          = z[VEC_W-1:0];
        r.zero_length     = zl;
        r.singular_matrix = sg;
        return r;
    endfunction

    function automatic normal_row_t row_of(nvtn_in_t v, bit typed, nvtn_out_t r);
        normal_row_t row;
        row.vec    = v;
        row.typed  = typed;
        row.result = r;
        return row;
    endfunction

    function automatic logic [SLOT_W-1:0] random_entry();
        case ($urandom_range(0, 5))
            0: return SLOT_W'($urandom_range(0, 8) - 4);
            1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            2: return SLOT_W'($urandom_range(0, 8192) - 4096);
            default: return SLOT_W'($urandom());
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        return {random_entry(), random_entry(), random_entry()};
    endfunction

    function automatic logic [VEC_W-1:0] random_component(int kind);
        case (kind)
            0: return VEC_W'($urandom_range(0, 6) - 3);
            1: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: return VEC_W'($urandom());
        endcase
    endfunction

    function automatic nvtn_in_t random_normal();
        nvtn_in_t v;
        int       kind;
        kind = $urandom_range(0, 19);
        if (kind == 0)
        begin
            return '0;
        end
        kind = (kind < 4) ? 0 : ((kind < 6) ? 1 : 2);
        v.normal_x = random_component(kind);
        v.normal_y = random_component(kind);
        v.normal_z = random_component(kind);
        return v;
    endfunction

    normal_row_t directed [$];
    nvtn_out_t   no_result;

    initial
    begin
        int burst;
        int gap;
        int items_left;
        int phase_items;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_ROW0;
        cfg_data       = '0;
        normal_valid   = 1'b0;
        normal         = '0;
        unit_stall     = 1'b0;
        mismatch_count = 0;
        hold_request   = 1'b0;
        no_result      = '0;
        model_rows[0]  = 48'h0000_0000_1000;
        model_rows[1]  = 48'h0000_1000_0000;
        model_rows[2]  = 48'h1000_0000_0000;
        update_cofactors();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity after reset: axis vectors come out as exact unit vectors, the zero vector is flagged zero_length.
        directed.push_back(row_of(vec3(16384, 0, 0), 1, unit3(16384, 0, 0, 0, 0)));
        directed.push_back(row_of(vec3(-32768, 0, 0), 1, unit3(-16384, 0, 0, 0, 0)));
        directed.push_back(row_of(vec3(0, 32767, 0), 1, unit3(0, 16384, 0, 0, 0)));
        directed.push_back(row_of(vec3(0, 0, -1), 1, unit3(0, 0, -16384, 0, 0)));
        directed.push_back(row_of(vec3(0, 0, 0), 1, unit3(0, 0, 0, 1, 0)));
        directed.push_back(row_of(vec3(1, 1, 0), 0, no_result));
        directed.push_back(row_of(vec3(32767, 32767, 32767), 0, no_result));
        directed.push_back(row_of(vec3(-32768, -32768, -32768), 0, no_result));
        directed.push_back(row_of(vec3(-32768, 32767, 1), 0, no_result));
        directed.push_back(row_of(vec3(3, -4, 12), 0, no_result));
        foreach (directed[i])
        begin
            send_normal(directed[i].vec, directed[i].typed, directed[i].result, i % 3);
        end

        // Write to an unused index leaves the identity in place.
        write_row(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
        send_normal(vec3(0, 100, 0), 1, unit3(0, 16384, 0, 0, 0), 0);

        // Zero matrix: every beat is flagged singular, even a zero vector.
        load_matrix('0, '0, '0);
        send_normal(vec3(16384, 0, 0), 1, unit3(0, 0, 0, 0, 1), 0);
        send_normal(vec3(0, 0, 0), 1, unit3(0, 0, 0, 0, 1), 1);

        // Negated identity: its inverse-transpose negates the normal.
        load_matrix(48'h0000_0000_F000, 48'h0000_F000_0000, 48'hF000_0000_0000);
        send_normal(vec3(0, 0, 16384), 1, unit3(0, 0, -16384, 0, 0), 0);
        send_normal(vec3(-5, 7, 9), 0, no_result, 0);

        // Extreme entries.
        load_matrix(48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF, 48'h8000_8000_7FFF);
        send_normal(vec3(32767, -32768, 32767), 0, no_result, 0);
        send_normal(vec3(1, 0, 0), 0, no_result, 0);
        send_normal(vec3(0, 0, 0), 1, unit3(0, 0, 0, 1, 0), 0);

        // Random phases, each after a new matrix load.
        items_left = RANDOM_ITEMS;
        while (items_left > 0)
        begin
            case ($urandom_range(0, 5))
                0: load_matrix(random_row(), random_row(), model_rows[0]);
                1: load_matrix(48'h0000_0000_1000, 48'h0000_1000_0000,
                               48'h1000_0000_0000);
                default: load_matrix(random_row(), random_row(), random_row());
            endcase
            phase_items = (items_left < 250) ? items_left : 250;
            items_left  = items_left - phase_items;
            if (items_left < 700 && items_left + phase_items >= 700)
            begin
                hold_request = 1'b1;
            end
            while (phase_items > 0)
            begin
                burst = $urandom_range(1, 40);
                if (burst > phase_items)
                begin
                    burst = phase_items;
                end
                phase_items = phase_items - burst;
                for (int i = 0; i < burst; i++)
                begin
                    gap = (i == burst - 1) ? $urandom_range(1, 12) : 0;
                    send_normal(random_normal(), 0, no_result, gap);
                end
            end
        end

        normal_valid <= 1'b0;
        while (pending_units.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DRAIN) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/nvtn_pkg.sv
src/nvtn_cofactor.sv
src/nvtn_sqrt.sv
src/nvtn_div.sv
src/normal_vector_transform_normalize.sv
test/normal_vector_transform_normalize_tb.sv
